@@ sv/telemetry_frame_deframer_unit_defines.svh @@
// Assertion macros shared by the deframer RTL.
// Needs nothing else; include by bare file name where assertions are written.
`ifndef TELEMETRY_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define TELEMETRY_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tfd_pkg.sv @@
// Shared types, constants and helpers for the telemetry frame deframer.
// No dependencies; used by every module of the block.
package tfd_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ID    = 4'd1,
    PH_TYPE  = 4'd2,
    PH_APP0  = 4'd3,
    PH_APP1  = 4'd4,
    PH_VAL0  = 4'd5,
    PH_VAL1  = 4'd6,
    PH_VAL2  = 4'd7,
    PH_VAL3  = 4'd8,
    PH_CHECK = 4'd9
  } phase_t;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_ESCAPE = 2'd1;
  localparam logic [1:0] REG_DFM    = 2'd2;

  localparam logic [7:0] START_RST  = 8'h7E;
  localparam logic [7:0] ESCAPE_RST = 8'h7D;
  localparam logic [7:0] DFM_RST    = 8'h10;

  localparam logic [7:0] UNSTUFF_XOR = 8'h20;
  localparam logic [7:0] CHECK_BASE  = 8'hFF;

  localparam int FRAME_W = 56;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] escape_marker;
    logic [7:0] data_frame_marker;
  } cfg_t;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] app_id;
    logic [7:0]  node_id;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // 8-bit add with end-around carry
  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

@@ sv/tfd_fifo.sv @@
// Small frame queue between the deframer front and the output stage.
// Depends on tfd_pkg (frame_t, fifo_stat_t).
module tfd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tfd_pkg::frame_t din,
  input  logic            pop,
  output tfd_pkg::frame_t dout,
  output tfd_pkg::fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  tfd_pkg::frame_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  assign dout       = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

@@ sv/tfd_front.sv @@
// Deframer front: takes received bytes, unstuffs, tracks the frame phase,
// checks the sum and pushes accepted frames. Depends on tfd_pkg.
module tfd_front (
  input  logic             clk,
  input  logic             rst,
  input  tfd_pkg::cfg_t    cfg,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output logic             push,
  output tfd_pkg::frame_t  frame
);

  tfd_pkg::phase_t phase, phase_next;
  logic        pending, pending_next;
  logic [7:0]  node_id, node_id_next;
  logic [15:0] app_id, app_id_next;
  logic [31:0] value, value_next;
  logic [7:0]  run_sum, run_sum_next;

  logic [7:0] b;
  logic       is_start;
  logic       in_zone;

  assign is_start = (rx_byte == cfg.start_marker);
  assign b        = pending ? (rx_byte ^ tfd_pkg::UNSTUFF_XOR) : rx_byte;
  // escapes only count inside app ID, value and check fields
  assign in_zone  = (phase >= tfd_pkg::PH_APP0) && (phase <= tfd_pkg::PH_CHECK);

  always_comb begin
    phase_next     = phase;
    pending_next   = pending;
    node_id_next   = node_id;
    app_id_next    = app_id;
    value_next     = value;
    run_sum_next   = run_sum;
    push           = 1'b0;
    if (accept) begin
      if (is_start) begin
        // restart; pending unstuff carries over to the ID byte
        phase_next = tfd_pkg::PH_ID;
      end else begin
        pending_next = 1'b0;
        if ((b == cfg.escape_marker) && in_zone) begin
          pending_next = 1'b1;
        end else begin
          unique case (phase)
            tfd_pkg::PH_ID: begin
              node_id_next = b;
              phase_next   = tfd_pkg::PH_TYPE;
            end
            tfd_pkg::PH_TYPE: begin
              if (b == cfg.data_frame_marker) begin
                run_sum_next = b;
                phase_next   = tfd_pkg::PH_APP0;
              end else begin
                phase_next = tfd_pkg::PH_IDLE;
              end
            end
            tfd_pkg::PH_APP0: begin
              app_id_next[7:0] = b;
              run_sum_next     = tfd_pkg::eac_add(run_sum, b);
              phase_next       = tfd_pkg::PH_APP1;
            end
            tfd_pkg::PH_APP1: begin
              app_id_next[15:8] = b;
              run_sum_next      = tfd_pkg::eac_add(run_sum, b);
              phase_next        = tfd_pkg::PH_VAL0;
            end
            tfd_pkg::PH_VAL0: begin
              value_next[7:0] = b;
              run_sum_next    = tfd_pkg::eac_add(run_sum, b);
              phase_next      = tfd_pkg::PH_VAL1;
            end
            tfd_pkg::PH_VAL1: begin
              value_next[15:8] = b;
              run_sum_next     = tfd_pkg::eac_add(run_sum, b);
              phase_next       = tfd_pkg::PH_VAL2;
            end
            tfd_pkg::PH_VAL2: begin
              value_next[23:16] = b;
              run_sum_next      = tfd_pkg::eac_add(run_sum, b);
              phase_next        = tfd_pkg::PH_VAL3;
            end
            tfd_pkg::PH_VAL3: begin
              value_next[31:24] = b;
              run_sum_next      = tfd_pkg::eac_add(run_sum, b);
              phase_next        = tfd_pkg::PH_CHECK;
            end
            tfd_pkg::PH_CHECK: begin
              push       = (b == (tfd_pkg::CHECK_BASE - run_sum));
              phase_next = tfd_pkg::PH_IDLE;
            end
            default: begin
              phase_next = tfd_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= tfd_pkg::PH_IDLE;
      pending <= 1'b0;
    end else begin
      phase   <= phase_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    node_id   <= node_id_next;
    app_id    <= app_id_next;
    value     <= value_next;
    run_sum   <= run_sum_next;
  end

  assign frame.node_id   = node_id;
  assign frame.app_id    = app_id;
  assign frame.value     = value;

endmodule

@@ sv/tfd_back.sv @@
// Output stage: pulls frames from the queue into the master-side register.
// Depends on tfd_pkg (frame_t, fifo_stat_t).
module tfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  tfd_pkg::fifo_stat_t           stat,
  input  tfd_pkg::frame_t               head,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tfd_pkg::FRAME_W-1:0]   m_tdata
);

  tfd_pkg::frame_t out_q;

  // refill when empty or when the current transfer completes
  assign pop = !stat.empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_q <= head;
    end
  end

  assign m_tdata = out_q;

endmodule

@@ sv/telemetry_frame_deframer_unit.sv @@
// Telemetry frame deframer, top level.
// Input stream: one received byte per transfer on s_tdata[7:0].
// Output stream: one transfer per accepted frame on m_tdata, fields from bit 0:
//   node_id[7:0], app_id[23:8], value[55:24].
// Config: APB-style, registers at 0x0 start marker, 0x4 escape marker,
//   0x8 data-frame marker; write only while the block is idle.
// Throughput: one byte per cycle while s_tready is high; the per-byte state
//   update (phase, unstuff flag, end-around-carry sum) is registered in the front.
// Path: the check byte's transfer writes the frame into the queue; from the
//   queue it moves into the output register, which raises m_tvalid, once that
//   register is free or its current transfer completes.
// Stall: frames wait in the queue (QUEUE_DEPTH entries) plus the output
//   register; s_tready drops only when the queue is full.
// Reset: rst is synchronous, active high; the deframer returns to idle, the
//   queue empties and the markers take their default values.
// Depends on tfd_pkg, tfd_front, tfd_fifo, tfd_back and the defines header.
`include "telemetry_frame_deframer_unit_defines.svh"

module telemetry_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  // slave side; s_tdata: rx_byte[7:0]
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,
  // master side; m_tdata: node_id[7:0], app_id[23:8], value[55:24]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tfd_pkg::FRAME_W-1:0] m_tdata,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  tfd_pkg::cfg_t       cfg;
  tfd_pkg::frame_t     push_frame;
  tfd_pkg::frame_t     head;
  tfd_pkg::fifo_stat_t stat;
  logic                push;
  logic                pop;
  logic                s_xfer;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // config registers; only the low byte of pwdata is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker      <= tfd_pkg::START_RST;
      cfg.escape_marker     <= tfd_pkg::ESCAPE_RST;
      cfg.data_frame_marker <= tfd_pkg::DFM_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tfd_pkg::REG_START:  cfg.start_marker      <= pwdata[7:0];
        tfd_pkg::REG_ESCAPE: cfg.escape_marker     <= pwdata[7:0];
        tfd_pkg::REG_DFM:    cfg.data_frame_marker <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tfd_pkg::REG_START:  prdata = {24'd0, cfg.start_marker};
      tfd_pkg::REG_ESCAPE: prdata = {24'd0, cfg.escape_marker};
      tfd_pkg::REG_DFM:    prdata = {24'd0, cfg.data_frame_marker};
      default:             prdata = 32'd0;
    endcase
  end

  // a byte is taken whenever the queue can hold a possible frame
  assign s_tready = !stat.full;
  assign s_xfer   = s_tvalid && s_tready;

  tfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (s_xfer),
    .rx_byte (s_tdata),
    .push    (push),
    .frame   (push_frame)
  );

  tfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_frame),
    .pop  (pop),
    .dout (head),
    .stat (stat)
  );

  tfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // queue must never be written while full
  `TFD_ASSERT_NOW(a_no_overflow, clk, rst, push, !stat.full, "frame pushed into full queue")
  // frames appear only on an accepted input byte
  `TFD_ASSERT_NOW(a_push_on_xfer, clk, rst, push, s_tvalid && s_tready, "frame without input")
  // a waiting frame reaches an empty output register next cycle
  `TFD_ASSERT_NEXT(a_refill, clk, rst, !m_tvalid && !stat.empty, m_tvalid, "output not refilled")

endmodule
